/* hdl/aes_pkg.sv */
// AES-128 package: state type, S-box functions and shared constants.
// No dependencies; used by every module under hdl.
package aes_pkg;

  localparam int ROUND_KEY_COUNT = 11;
  localparam logic [7:0] POLY = 8'h1b;

  typedef enum logic [1:0] {ST_IDLE, ST_ROUND, ST_DONE} aes_state_t;

  typedef struct packed {
    logic       start;
    logic       kind;
    logic       step;
    logic       last;
  } aes_ctrl_t;

  function automatic logic [7:0] sbox(input logic [7:0] v);
    logic [7:0] t [256];
    t = '{
 8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
 8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
 8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
 8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
 8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
 8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
 8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
 8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
 8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
 8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
 8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
 8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
 8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
 8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
 8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
 8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
    return t[v];
  endfunction

  function automatic logic [7:0] sbox_rev(input logic [7:0] v);
    logic [7:0] t [256];
    t = '{
 8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
 8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
 8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
 8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
 8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
 8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
 8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
 8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
 8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
 8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
 8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
 8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
 8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
 8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
 8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
 8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
    return t[v];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? POLY : 8'h00);
  endfunction

endpackage

/* hdl/aes_key_exp.sv */
// Round key store and iterative key expansion, one round key per cycle.
// Depends on aes_pkg.
module aes_key_exp #(
  parameter int RK_COUNT = aes_pkg::ROUND_KEY_COUNT
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [127:0] key,
  input  logic [3:0]   rd_idx,
  output logic [127:0] rd_key,
  output logic         busy
);

  logic [127:0] rk_r [RK_COUNT];
  logic [127:0] cur_r, cur_nxt;
  logic [3:0]   idx_r, idx_nxt;
  logic [7:0]   rc_r, rc_nxt;
  logic         busy_r, busy_nxt;
  logic [31:0]  t;

  always_comb begin
    t = {aes_pkg::sbox(cur_r[23:16]) ^ rc_r, aes_pkg::sbox(cur_r[15:8]),
         aes_pkg::sbox(cur_r[7:0]), aes_pkg::sbox(cur_r[31:24])};
    cur_nxt[127:96] = cur_r[127:96] ^ t;
    cur_nxt[95:64]  = cur_r[95:64] ^ cur_nxt[127:96];
    cur_nxt[63:32]  = cur_r[63:32] ^ cur_nxt[95:64];
    cur_nxt[31:0]   = cur_r[31:0] ^ cur_nxt[63:32];
    idx_nxt  = idx_r + 4'd1;
    rc_nxt   = aes_pkg::xtime(rc_r);
    busy_nxt = busy_r && (idx_r != 4'(RK_COUNT - 1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      idx_r  <= '0;
      cur_r  <= '0;
      rc_r   <= 8'h01;
    end else if (start) begin
      busy_r <= 1'b1;
      idx_r  <= '0;
      cur_r  <= key;
      rc_r   <= 8'h01;
    end else if (busy_r) begin
      rk_r[idx_r] <= cur_r;
      cur_r  <= cur_nxt;
      idx_r  <= idx_nxt;
      rc_r   <= rc_nxt;
      busy_r <= busy_nxt;
    end
  end

  assign rd_key = rk_r[rd_idx];
  assign busy   = busy_r;

endmodule

/* hdl/aes_round.sv */
// Shared round datapath: one encrypt or decrypt round per cycle on the state.
// Depends on aes_pkg.
module aes_round (
  input  logic               clk,
  input  aes_pkg::aes_ctrl_t ctrl,
  input  logic [127:0]       din,
  input  logic [127:0]       rkey,
  output logic [127:0]       dout
);

  logic [127:0] st_r, st_nxt;
  logic [7:0] s [16];
  logic [7:0] a [16];
  logic [7:0] b [16];
  logic [7:0] m [16];
  logic [7:0] k [16];
  logic [7:0] all, u, v;

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      s[i] = st_r[127-8*i -: 8];
      k[i] = rkey[127-8*i -: 8];
    end
    // forward: sub then shift; inverse: shift then sub, then key, then mix
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        if (!ctrl.kind) begin
          a[r+4*c] = aes_pkg::sbox(s[r+4*((c+r)%4)]);
        end else begin
          a[r+4*((c+r)%4)] = aes_pkg::sbox_rev(s[r+4*c]);
        end
      end
    end
    for (int i = 0; i < 16; i++) b[i] = ctrl.kind ? (a[i] ^ k[i]) : a[i];
    for (int c = 0; c < 4; c++) begin
      u = aes_pkg::xtime(aes_pkg::xtime(b[4*c] ^ b[4*c+2]));
      v = aes_pkg::xtime(aes_pkg::xtime(b[4*c+1] ^ b[4*c+3]));
      if (ctrl.kind) begin
        m[4*c] = b[4*c] ^ u; m[4*c+1] = b[4*c+1] ^ v;
        m[4*c+2] = b[4*c+2] ^ u; m[4*c+3] = b[4*c+3] ^ v;
      end else begin
        m[4*c] = b[4*c]; m[4*c+1] = b[4*c+1];
        m[4*c+2] = b[4*c+2]; m[4*c+3] = b[4*c+3];
      end
      all = m[4*c] ^ m[4*c+1] ^ m[4*c+2] ^ m[4*c+3];
      for (int j = 0; j < 4; j++) begin
        a[0] = m[4*c+j] ^ all ^ aes_pkg::xtime(m[4*c+j] ^ m[4*c+((j+1)%4)]);
        b[4*c+j] = ctrl.last ? b[4*c+j] : a[0];
      end
    end
    for (int i = 0; i < 16; i++) begin
      st_nxt[127-8*i -: 8] = ctrl.kind ? b[i] : (b[i] ^ k[i]);
    end
  end

  // hold the finished state while the result waits
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      st_r <= din ^ rkey;
    end else if (ctrl.step) begin
      st_r <= st_nxt;
    end
  end

  assign dout = st_r;

endmodule

/* hdl/aes128_block_cipher.sv */
// AES-128 ECB core top level: APB key registers, sequencer, result register.
// Depends on aes_pkg, aes_key_exp and aes_round.
// The initial key addition is done as the block is loaded, then ten rounds run
// through a single shared round unit; the result is held until taken and the
// next block is taken from the cycle after, so a new block is not accepted
// before the last one's result has been taken.
// Writing either key register re-expands the key: the write is first latched
// (wr_d_r), which restarts the expansion, and no block is accepted until it is
// done; after reset the same expansion of the all-zero key runs first.
module aes128_block_cipher #(
  parameter int RK_COUNT = aes_pkg::ROUND_KEY_COUNT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_kind,
  input  logic [63:0] in_block_high,
  input  logic [63:0] in_block_low,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_out_high,
  output logic [63:0] out_out_low,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  output logic [63:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam logic [0:0] REG_KEY_HIGH = 1'b0;
  localparam logic [0:0] REG_KEY_LOW  = 1'b1;

  aes_pkg::aes_state_t state_r, state_nxt;
  aes_pkg::aes_ctrl_t  ctrl;
  logic [63:0]  key_hi_r, key_lo_r;
  logic         kind_r, wr, kbusy, accept;
  logic [3:0]   rnd_r, rnd_nxt, rd_idx;
  logic [127:0] rkey, dout;

  assign cfg_pready = 1'b1;
  assign wr = cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr[2:0] == 3'd0)
              && (cfg_paddr[3:3] == REG_KEY_HIGH || cfg_paddr[3:3] == REG_KEY_LOW);
  assign cfg_prdata = (cfg_paddr[3:3] == REG_KEY_LOW) ? key_lo_r : key_hi_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_hi_r <= '0;
      key_lo_r <= '0;
    end else if (wr) begin
      if (cfg_paddr[3:3] == REG_KEY_HIGH) key_hi_r <= cfg_pwdata;
      else key_lo_r <= cfg_pwdata;
    end
  end

  logic         wr_d_r;
  always_ff @(posedge clk) begin
    if (!rst_n) wr_d_r <= 1'b0;
    else wr_d_r <= wr;
  end

  aes_key_exp #(.RK_COUNT(RK_COUNT)) u_key (
    .clk(clk), .rst_n(rst_n), .start(wr_d_r), .key({key_hi_r, key_lo_r}),
    .rd_idx(rd_idx), .rd_key(rkey), .busy(kbusy)
  );

  assign in_ready = (state_r == aes_pkg::ST_IDLE) && !kbusy && !wr_d_r;
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    rnd_nxt   = rnd_r;
    case (state_r)
      aes_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = aes_pkg::ST_ROUND;
          rnd_nxt   = 4'd1;
        end
      end
      aes_pkg::ST_ROUND: begin
        rnd_nxt = rnd_r + 4'd1;
        if (rnd_r == 4'(RK_COUNT - 1)) state_nxt = aes_pkg::ST_DONE;
      end
      aes_pkg::ST_DONE: begin
        if (out_ready) state_nxt = aes_pkg::ST_IDLE;
      end
      default: state_nxt = aes_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= aes_pkg::ST_IDLE;
      rnd_r   <= '0;
    end else begin
      state_r <= state_nxt;
      rnd_r   <= rnd_nxt;
    end
    if (accept) kind_r <= in_kind;
  end

  // decrypt walks the round keys backwards
  always_comb begin
    ctrl.start = accept;
    ctrl.kind  = kind_r;
    ctrl.step  = (state_r == aes_pkg::ST_ROUND);
    ctrl.last  = (rnd_r == 4'(RK_COUNT - 1));
    if (accept) begin
      rd_idx = in_kind ? 4'(RK_COUNT - 1) : 4'd0;
    end else begin
      rd_idx = kind_r ? 4'(RK_COUNT - 1) - rnd_r : rnd_r;
    end
  end

  aes_round u_round (
    .clk(clk), .ctrl(ctrl), .din({in_block_high, in_block_low}),
    .rkey(rkey), .dout(dout)
  );

  assign out_valid    = (state_r == aes_pkg::ST_DONE);
  assign out_out_high = dout[127:64];
  assign out_out_low  = dout[63:0];

endmodule

/* verif/tb_aes128_block_cipher.sv */
// Self-checking testbench for the AES-128 ECB core: APB key writes, random blocks in
// both directions, a scoreboard class holding the expected ciphertext/plaintext.
// Depends on aes_pkg and the aes128_block_cipher RTL only.
module tb_aes128_block_cipher;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_RANDOM = 1000;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int KEY_HIGH_ADDR = 0;
  localparam int KEY_LOW_ADDR = 8;
  localparam bit KIND_ENC = 1'b0;
  localparam bit KIND_DEC = 1'b1;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_kind = 1'b0;
  logic [63:0] in_block_high = '0;
  logic [63:0] in_block_low = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] out_out_high;
  logic [63:0] out_out_low;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [3:0]  cfg_paddr = '0;
  logic [63:0] cfg_pwdata = '0;
  logic [63:0] cfg_prdata;
  logic        cfg_pready;

  aes128_block_cipher u_dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  class cipher_scoreboard;
    logic [63:0] key_hi, key_lo;
    logic [127:0] round_keys [11];
    logic [127:0] pending_blocks [$];
    int errors;

    function logic [7:0] sb(logic [7:0] v);
      return aes_pkg::sbox(v);
    endfunction

    function logic [7:0] inv_sb(logic [7:0] v);
      logic [7:0] i;
      for (int k = 0; k < 256; k++) begin
        i = k[7:0];
        if (sb(i) == v) return i;
      end
      return 8'h00;
    endfunction

    function logic [7:0] dbl(logic [7:0] v);
      return {v[6:0], 1'b0} ^ (v[7] ? aes_pkg::POLY : 8'h00);
    endfunction

    // byte i of a 128-bit state sits at bits [127-8i -: 8]
    function void expand();
      logic [31:0] w [44];
      logic [31:0] t;
      logic [7:0] rc;
      logic [127:0] k;
      k = {key_hi, key_lo};
      rc = 8'h01;
      for (int i = 0; i < 4; i++) w[i] = k[127 - 32*i -: 32];
      for (int i = 4; i < 44; i++) begin
        t = w[i-1];
        if (i % 4 == 0) begin
          t = {t[23:0], t[31:24]};
          t = {sb(t[31:24]) ^ rc, sb(t[23:16]), sb(t[15:8]), sb(t[7:0])};
          rc = dbl(rc);
        end
        w[i] = w[i-4] ^ t;
      end
      for (int r = 0; r < 11; r++) round_keys[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
    endfunction

    function void reset_key();
      key_hi = '0;
      key_lo = '0;
      expand();
    endfunction

    function void set_key(int addr, logic [63:0] val);
      if (addr == KEY_HIGH_ADDR) key_hi = val;
      else key_lo = val;
      expand();
    endfunction

    function logic [127:0] shift(logic [127:0] s, bit inverse);
      logic [127:0] t;
      for (int r = 0; r < 4; r++)
        for (int c = 0; c < 4; c++)
          if (inverse) t[127 - 8*(r + 4*((c + r) % 4)) -: 8] = s[127 - 8*(r + 4*c) -: 8];
          else t[127 - 8*(r + 4*c) -: 8] = s[127 - 8*(r + 4*((c + r) % 4)) -: 8];
      return t;
    endfunction

    function logic [127:0] mix(logic [127:0] s, bit inverse);
      logic [7:0] a0, a1, a2, a3, all, u, v;
      for (int c = 0; c < 4; c++) begin
        a0 = s[127 - 32*c -: 8];
        a1 = s[119 - 32*c -: 8];
        a2 = s[111 - 32*c -: 8];
        a3 = s[103 - 32*c -: 8];
        if (inverse) begin
          u = dbl(dbl(a0 ^ a2));
          v = dbl(dbl(a1 ^ a3));
          a0 ^= u; a1 ^= v; a2 ^= u; a3 ^= v;
        end
        all = a0 ^ a1 ^ a2 ^ a3;
        s[127 - 32*c -: 32] = {a0 ^ all ^ dbl(a0 ^ a1), a1 ^ all ^ dbl(a1 ^ a2),
                               a2 ^ all ^ dbl(a2 ^ a3), a3 ^ all ^ dbl(a3 ^ a0)};
      end
      return s;
    endfunction

    function logic [127:0] sub(logic [127:0] s, bit inverse);
      for (int i = 0; i < 16; i++)
        s[127 - 8*i -: 8] = inverse ? inv_sb(s[127 - 8*i -: 8]) : sb(s[127 - 8*i -: 8]);
      return s;
    endfunction

    function void note_block(bit kind, logic [63:0] hi, logic [63:0] lo);
      logic [127:0] s;
      s = {hi, lo};
      if (kind == KIND_ENC) begin
        s ^= round_keys[0];
        for (int r = 1; r < 11; r++) begin
          s = shift(sub(s, 1'b0), 1'b0);
          if (r != 10) s = mix(s, 1'b0);
          s ^= round_keys[r];
        end
      end else begin
        s ^= round_keys[10];
        for (int r = 9; r >= 0; r--) begin
          s = sub(shift(s, 1'b1), 1'b1);
          s ^= round_keys[r];
          if (r != 0) s = mix(s, 1'b1);
        end
      end
      pending_blocks.push_back(s);
    endfunction

    function void check_block(logic [63:0] hi, logic [63:0] lo);
      logic [127:0] exp_s;
      if (pending_blocks.size() == 0) begin
        $display("%0t: unexpected result %h %h", $time, hi, lo);
        errors++;
        return;
      end
      exp_s = pending_blocks.pop_front();
      if (hi !== exp_s[127:64]) begin
        $display("%0t: out_high expected %h actual %h", $time, exp_s[127:64], hi);
        errors++;
      end
      if (lo !== exp_s[63:0]) begin
        $display("%0t: out_low expected %h actual %h", $time, exp_s[63:0], lo);
        errors++;
      end
    endfunction
  endclass

  cipher_scoreboard board = new();
  int idle_cycles = 0;
  bit sink_hold = 1'b0;

  task automatic write_key(int addr, logic [63:0] val);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr[3:0];
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    board.set_key(addr, val);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  // valid stays up across back-to-back beats; drop it only for a gap
  task automatic send_block(bit kind, logic [63:0] hi, logic [63:0] lo, int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_block_high <= hi;
    in_block_low <= lo;
    do @(posedge clk); while (!in_ready);
    board.note_block(kind, hi, lo);
  endtask

  // drain, then let any key expansion finish before touching the keys
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (board.pending_blocks.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [63:0] rand_edge64();
    case ($urandom_range(3))
      0: return '0;
      1: return '1;
      default: return rand64();
    endcase
  endfunction

  // receiver: random stalls plus one long hold-off
  initial begin
    int stall;
    @(posedge rst_n);
    forever begin
      if (sink_hold) begin
        out_ready <= 1'b0;
        repeat (60) @(posedge clk);
        sink_hold = 1'b0;
      end
      stall = ($urandom_range(3) == 0) ? 0 : $urandom_range(8);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      board.check_block(out_out_high, out_out_low);
    end
  end

  // watchdog on cycles with no beat on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    logic [63:0] pt_hi, pt_lo;
    board.reset_key();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // all-zero key after reset, extremes of the block
    send_block(KIND_ENC, '0, '0, 0);
    send_block(KIND_DEC, '0, '0, 0);
    send_block(KIND_ENC, '1, '1, 0);
    send_block(KIND_DEC, '1, '1, 1);
    wait_drained();
    // known FIPS-197 key, then a partial update of one half only
    write_key(KEY_HIGH_ADDR, 64'h0001020304050607);
    write_key(KEY_LOW_ADDR, 64'h08090a0b0c0d0e0f);
    send_block(KIND_ENC, 64'h0011223344556677, 64'h8899aabbccddeeff, 0);
    send_block(KIND_DEC, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a, 0);
    send_block(KIND_DEC, 64'h0011223344556677, 64'h8899aabbccddeeff, 2);
    wait_drained();
    write_key(KEY_LOW_ADDR, '1);
    send_block(KIND_ENC, 64'h8000000000000000, 64'h1, 0);
    send_block(KIND_DEC, 64'h8000000000000000, 64'h1, 0);
    wait_drained();
    write_key(KEY_HIGH_ADDR, '1);
    send_block(KIND_ENC, '0, '1, 0);
    send_block(KIND_DEC, '1, '0, 0);
    wait_drained();

    // long receiver hold-off while blocks keep coming
    sink_hold = 1'b1;
    for (int i = 0; i < 10; i++) send_block(i[0], rand64(), rand64(), 0);
    wait_drained();

    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (i % 200 == 199) begin
        wait_drained();
        write_key($urandom_range(1) ? KEY_HIGH_ADDR : KEY_LOW_ADDR, rand_edge64());
        if ($urandom_range(1)) write_key(KEY_LOW_ADDR, rand_edge64());
      end
      pt_hi = rand_edge64();
      pt_lo = rand_edge64();
      if (i % 100 < 25) send_block(1'($urandom_range(1)), pt_hi, pt_lo, 0);
      else send_block(1'($urandom_range(1)), pt_hi, pt_lo, $urandom_range(8));
    end

    wait_drained();
    repeat (30) @(posedge clk);
    if (board.errors == 0 && board.pending_blocks.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
